[design/odt_pkg.sv]
// Shared types, constants and register codes for the ordered dither threshold unit.
package odt_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_MAX_LOG_DIM = 4;

    // Fixed field widths.
    localparam int SAMPLE_W     = 8;
    localparam int LOG_DIM_W    = 3;
    localparam int LINE_WIDTH_W = 13;
    localparam int CHAN_CNT_W   = 3;
    localparam int CHAN_IDX_W   = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    // Channel count limit and output levels.
    localparam logic [CHAN_CNT_W-1:0] MAX_CHANNELS = 3'd4;
    localparam logic [SAMPLE_W-1:0]   LEVEL_LOW    = 8'h00;
    localparam logic [SAMPLE_W-1:0]   LEVEL_HIGH   = 8'hFF;

    // Register reset values.
    localparam logic [LOG_DIM_W-1:0]    RST_LOG_DIM       = 3'd2;
    localparam logic [LINE_WIDTH_W-1:0] RST_LINE_WIDTH    = 13'd640;
    localparam logic [CHAN_CNT_W-1:0]   RST_CHANNEL_COUNT = 3'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOG_DIM       = 2'd0,
        CFG_LINE_WIDTH    = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_index_t;

    // Raw configuration register contents.
    typedef struct packed {
        logic [LOG_DIM_W-1:0]    log_dim;
        logic [LINE_WIDTH_W-1:0] line_width;
        logic [CHAN_CNT_W-1:0]   channel_count;
    } cfg_t;

    // Base-4 digit of the 2x2 pattern, indexed by {row bit, column bit}.
    localparam logic [1:0] PATTERN_DIGIT [4] = '{2'd1, 2'd2, 2'd3, 2'd0};

endpackage

[design/odt_position.sv]
// Raster position tracker: channel, column and row phase counters.
module odt_position #(
    parameter int MAX_WIDTH   = odt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_LOG_DIM = odt_pkg::DEF_MAX_LOG_DIM
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  odt_pkg::cfg_t                      cfg,
    input  logic                               advance,
    input  logic                               start_of_frame,
    output logic [MAX_LOG_DIM-1:0]             row_bits,
    output logic [MAX_LOG_DIM-1:0]             col_bits,
    output logic [odt_pkg::LOG_DIM_W-1:0]      log_dim_eff
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W = COL_W + 1;
    localparam int EXT_W = COL_W + MAX_LOG_DIM;

    logic [COL_W-1:0]                  col_reg, col_next, col_eff;
    logic [MAX_LOG_DIM-1:0]            row_reg, row_next, row_eff;
    logic [odt_pkg::CHAN_IDX_W-1:0]    chan_reg, chan_next, chan_eff;
    logic [31:0]                       width_full;
    logic [WID_W-1:0]                  width_eff;
    logic [WID_W-1:0]                  col_inc;
    logic [odt_pkg::CHAN_CNT_W-1:0]    chans_eff;
    logic [odt_pkg::CHAN_CNT_W-1:0]    chan_inc;
    logic [EXT_W-1:0]                  col_ext;

    // Clamp the configured limits into their legal ranges.
    always_comb begin
        if (cfg.log_dim == '0) begin
            log_dim_eff = odt_pkg::LOG_DIM_W'(1);
        end else if (cfg.log_dim > odt_pkg::LOG_DIM_W'(MAX_LOG_DIM)) begin
            log_dim_eff = odt_pkg::LOG_DIM_W'(MAX_LOG_DIM);
        end else begin
            log_dim_eff = cfg.log_dim;
        end

        if (cfg.line_width == '0) begin
            width_full = 32'd1;
        end else if (32'(cfg.line_width) > 32'(MAX_WIDTH)) begin
            width_full = 32'(MAX_WIDTH);
        end else begin
            width_full = 32'(cfg.line_width);
        end
        width_eff = WID_W'(width_full);

        if (cfg.channel_count == '0) begin
            chans_eff = odt_pkg::CHAN_CNT_W'(1);
        end else if (cfg.channel_count > odt_pkg::MAX_CHANNELS) begin
            chans_eff = odt_pkg::MAX_CHANNELS;
        end else begin
            chans_eff = cfg.channel_count;
        end
    end

    // A start of frame puts this sample at the origin.
    always_comb begin
        if (start_of_frame) begin
            col_eff  = '0;
            row_eff  = '0;
            chan_eff = '0;
        end else begin
            col_eff  = col_reg;
            row_eff  = row_reg;
            chan_eff = chan_reg;
        end
        col_ext  = EXT_W'(col_eff);
        col_bits = col_ext[MAX_LOG_DIM-1:0];
        row_bits = row_eff;
    end

    // Advance channel, then column, then row; a counter at or past its limit wraps.
    always_comb begin
        col_inc   = WID_W'(col_eff) + WID_W'(1);
        chan_inc  = odt_pkg::CHAN_CNT_W'(chan_eff) + odt_pkg::CHAN_CNT_W'(1);
        col_next  = col_eff;
        row_next  = row_eff;
        chan_next = chan_eff;
        if (chan_inc >= chans_eff) begin
            chan_next = '0;
            if (col_inc >= width_eff) begin
                col_next = '0;
                row_next = row_eff + MAX_LOG_DIM'(1);
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end else begin
            chan_next = chan_inc[odt_pkg::CHAN_IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            chan_reg <= '0;
        end else if (advance) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            chan_reg <= chan_next;
        end
    end

endmodule

[design/odt_threshold.sv]
// Bayer index, threshold and compare for one registered sample.
module odt_threshold #(
    parameter int MAX_LOG_DIM = odt_pkg::DEF_MAX_LOG_DIM
) (
    input  logic [MAX_LOG_DIM-1:0]            row_bits,
    input  logic [MAX_LOG_DIM-1:0]            col_bits,
    input  logic [odt_pkg::LOG_DIM_W-1:0]     log_dim,
    input  logic [odt_pkg::SAMPLE_W-1:0]      sample,
    output logic [odt_pkg::SAMPLE_W-1:0]      dithered
);

    localparam int D_W = 2 * MAX_LOG_DIM;
    localparam int P_W = D_W + 1 + odt_pkg::SAMPLE_W;

    logic [D_W-1:0]                 index;
    logic [D_W:0]                   odd_index;
    logic [P_W-1:0]                 product;
    logic [P_W-1:0]                 scaled;
    logic [odt_pkg::LOG_DIM_W:0]    shift;
    logic [odt_pkg::SAMPLE_W-1:0]   thresh;

    // Interleave one base-4 digit per bit level; the top used level lands lowest.
    always_comb begin
        int sh;
        index = '0;
        for (int k = 0; k < MAX_LOG_DIM; k++) begin
            sh = 0;
            if (k < int'(log_dim)) begin
                sh    = 2 * (int'(log_dim) - 1 - k);
                index = index | (D_W'(odt_pkg::PATTERN_DIGIT[{row_bits[k], col_bits[k]}]) << sh);
            end
        end
    end

    // Threshold ((2d+1)*255) >> (2*log_dim+1); 255x is formed as 256x - x.
    always_comb begin
        odd_index = {index, 1'b1};
        product   = (P_W'(odd_index) << odt_pkg::SAMPLE_W) - P_W'(odd_index);
        shift     = {log_dim, 1'b1};
        scaled    = product >> shift;
        thresh    = scaled[odt_pkg::SAMPLE_W-1:0];
        dithered  = (sample <= thresh) ? odt_pkg::LEVEL_LOW : odt_pkg::LEVEL_HIGH;
    end

endmodule

[design/ordered_dither_threshold_unit.sv]
// Top level of the ordered dither threshold unit: config registers and two-stage pipeline.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: sample; tuser: start_of_frame
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: dithered
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One sample is taken per cycle unless m_axis stalls.
// The position counters update in the accept cycle; the input register feeds the
// index, threshold and compare logic into the result register.
// Stalls on m_axis back up through the result register; an empty input register still
// takes a sample while a finished result waits. cfg_ready is always high.
// aresetn is synchronous: it clears counters and valid flags and loads config defaults.
module ordered_dither_threshold_unit #(
    parameter int MAX_WIDTH   = odt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_LOG_DIM = odt_pkg::DEF_MAX_LOG_DIM
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [odt_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [7:0] sample
    input  logic                               s_axis_tuser,   // [0] start_of_frame
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [odt_pkg::SAMPLE_W-1:0]       m_axis_tdata,   // [7:0] dithered
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [odt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [odt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    odt_pkg::cfg_t                     cfg_reg;
    logic                              s_accept;
    logic                              out_load;
    logic [MAX_LOG_DIM-1:0]            row_bits, col_bits;
    logic [odt_pkg::LOG_DIM_W-1:0]     log_dim_eff;
    logic [odt_pkg::SAMPLE_W-1:0]      dithered;

    logic                              s1_valid_reg, s1_valid_next;
    logic [odt_pkg::SAMPLE_W-1:0]      s1_sample_reg;
    logic [MAX_LOG_DIM-1:0]            s1_row_reg, s1_col_reg;
    logic [odt_pkg::LOG_DIM_W-1:0]     s1_lg_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [odt_pkg::SAMPLE_W-1:0]      out_data_reg;

    // Configuration register writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.log_dim       <= odt_pkg::RST_LOG_DIM;
            cfg_reg.line_width    <= odt_pkg::RST_LINE_WIDTH;
            cfg_reg.channel_count <= odt_pkg::RST_CHANNEL_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            case (odt_pkg::cfg_index_t'(cfg_index))
                odt_pkg::CFG_LOG_DIM: begin
                    cfg_reg.log_dim <= cfg_data[odt_pkg::LOG_DIM_W-1:0];
                end
                odt_pkg::CFG_LINE_WIDTH: begin
                    cfg_reg.line_width <= cfg_data[odt_pkg::LINE_WIDTH_W-1:0];
                end
                odt_pkg::CFG_CHANNEL_COUNT: begin
                    cfg_reg.channel_count <= cfg_data[odt_pkg::CHAN_CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake flow between the two stages.
    assign out_load       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !s1_valid_reg || out_load;
    assign s_accept       = s_axis_tvalid && s_axis_tready;
    assign s1_valid_next  = s_accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    odt_position #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_LOG_DIM (MAX_LOG_DIM)
    ) u_position (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .advance        (s_accept),
        .start_of_frame (s_axis_tuser),
        .row_bits       (row_bits),
        .col_bits       (col_bits),
        .log_dim_eff    (log_dim_eff)
    );

    // Input register: sample with its matrix position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
        if (s_accept) begin
            s1_sample_reg <= s_axis_tdata;
            s1_row_reg    <= row_bits;
            s1_col_reg    <= col_bits;
            s1_lg_reg     <= log_dim_eff;
        end
    end

    odt_threshold #(
        .MAX_LOG_DIM (MAX_LOG_DIM)
    ) u_threshold (
        .row_bits (s1_row_reg),
        .col_bits (s1_col_reg),
        .log_dim  (s1_lg_reg),
        .sample   (s1_sample_reg),
        .dithered (dithered)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (out_load) begin
            out_data_reg <= dithered;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // An empty input register always takes a sample.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_axis_tready)
        else $error("input stage empty but not ready");

    // A held sample is not dropped while the result register is stalled.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_valid_reg && !m_axis_tready) |=> s1_valid_reg)
        else $error("held sample lost during output stall");

    // Every delivered result is one of the two output levels.
    a_two_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata == odt_pkg::LEVEL_LOW ||
                           m_axis_tdata == odt_pkg::LEVEL_HIGH))
        else $error("result is neither low nor high level");
`endif

endmodule
